FILE: hdl/particle_pool_engine_unit_macros.svh
`ifndef PARTICLE_POOL_ENGINE_UNIT_MACROS_SVH
`define PARTICLE_POOL_ENGINE_UNIT_MACROS_SVH

// clocked assertion, quiet while in reset
`define PPE_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication
`define PPE_ASSERT_IMP(lbl, ante, cons, msg) \
  `PPE_ASSERT_CLK(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define PPE_ASSERT_NXT(lbl, ante, cons, msg) \
  `PPE_ASSERT_CLK(lbl, (ante) |=> (cons), msg)

`endif

FILE: hdl/ppe_pkg.sv
`default_nettype none

package ppe_pkg;

  localparam int POOL_ENTRIES = 4096;
  localparam int ADDR_W       = $clog2(POOL_ENTRIES);
  localparam int CNT_W        = $clog2(POOL_ENTRIES + 1);
  localparam int RIDX_W       = 12;
  localparam int POS_W        = 24;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_SPAWN = 2'd1,
    CMD_READ  = 2'd2,
    CMD_KILL  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [15:0]      dir_x;
    logic signed [15:0]      dir_y;
    logic [15:0]             speed;
    logic [15:0]             lifetime;
    logic [15:0]             age;
  } entry_t;

  // position plus floor(prod / 2^14), saturated to Q16.8
  function automatic logic signed [POS_W-1:0] pos_advance(
    input logic signed [POS_W-1:0] pos,
    input logic signed [32:0]      prod
  );
    logic signed [18:0] step;
    logic signed [25:0] sum;
    step = prod[32:14];
    sum  = {{2{pos[POS_W-1]}}, pos} + {{7{step[18]}}, step};
    if (sum[25:23] == 3'b000 || sum[25:23] == 3'b111) begin
      return sum[POS_W-1:0];
    end else if (sum[25]) begin
      return {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      return {1'b0, {(POS_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

FILE: hdl/particle_pool_engine_unit.sv
// throughput: one command at a time; tick and spawn visit one pool entry per cycle,
// bound by the single read port of the flag and entry memories
// reset: synchronous, active low; afterwards a clearing pass writes all POOL_ENTRIES (4096)
// active flags to zero, with in_stall high until it ends
`default_nettype none
`include "particle_pool_engine_unit_macros.svh"

module particle_pool_engine_unit import ppe_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [1:0]               in_command,
  input  wire logic [11:0]              in_entry_index,
  input  wire logic signed [23:0]       in_start_x,
  input  wire logic signed [23:0]       in_start_y,
  input  wire logic signed [15:0]       in_heading_x,
  input  wire logic signed [15:0]       in_heading_y,
  input  wire logic [15:0]              in_speed,
  input  wire logic [15:0]              in_lifetime_ms,
  input  wire logic [9:0]               in_delta_ms,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          out_found,
  output logic [11:0]                   out_result_index,
  output logic                          out_entry_active,
  output logic signed [23:0]            out_read_x,
  output logic signed [23:0]            out_read_y,
  output logic [15:0]                   out_read_age_ms
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_TICK  = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_READ  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(POOL_ENTRIES - 1);
  localparam logic [CNT_W-1:0]  POOL_CNT  = CNT_W'(POOL_ENTRIES);

  state_t state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [CNT_W-1:0]  issue_r, issue_nxt;
  logic              s1_valid_r, s1_valid_nxt;
  logic [ADDR_W-1:0] s1_addr_r, s1_addr_nxt;

  logic              s2_valid_r;
  logic [ADDR_W-1:0] s2_addr_r;
  entry_t            s2_ent_r;
  logic signed [32:0] s2_px_r, s2_py_r;
  logic              s2_expire_r;

  // storage
  logic   act_mem [POOL_ENTRIES];
  entry_t dat_mem [POOL_ENTRIES];
  logic   act_rd_r;
  entry_t dat_rd_r;

  logic [ADDR_W-1:0] rd_addr;
  logic              act_we, act_wdata;
  logic [ADDR_W-1:0] act_waddr;
  logic              dat_we;
  logic [ADDR_W-1:0] dat_waddr;
  entry_t            dat_wdata;
  entry_t            tick_word;

  // latched command word
  logic        in_range_r;
  logic [9:0]  delta_r;
  entry_t      spawn_r;

  logic                    res_found_r, res_found_nxt;
  logic [RIDX_W-1:0]       res_index_r, res_index_nxt;
  logic                    res_active_r, res_active_nxt;
  logic signed [POS_W-1:0] res_x_r, res_x_nxt;
  logic signed [POS_W-1:0] res_y_r, res_y_nxt;
  logic [15:0]             res_age_r, res_age_nxt;

  logic                    out_valid_r;
  logic                    out_found_r;
  logic [RIDX_W-1:0]       out_index_r;
  logic                    out_active_r;
  logic signed [POS_W-1:0] out_x_r, out_y_r;
  logic [15:0]             out_age_r;

  logic              in_acc;
  logic              idx_in_range;
  logic              out_load;
  logic signed [32:0] prod_x, prod_y;
  logic [16:0]       age_sum;
  logic [15:0]       age_sat;

  assign in_stall     = (state_r != ST_IDLE);
  assign in_acc       = in_valid && !in_stall;
  assign idx_in_range = (32'(in_entry_index) < POOL_ENTRIES);
  assign out_load     = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // first tick stage: multiply and age update
  assign prod_x  = 33'($signed(dat_rd_r.dir_x)) * 33'($signed({1'b0, dat_rd_r.speed}));
  assign prod_y  = 33'($signed(dat_rd_r.dir_y)) * 33'($signed({1'b0, dat_rd_r.speed}));
  assign age_sum = {1'b0, dat_rd_r.age} + {7'd0, delta_r};
  assign age_sat = age_sum[16] ? 16'hFFFF : age_sum[15:0];

  // second tick stage: position add and saturate
  always_comb begin
    tick_word       = s2_ent_r;
    tick_word.pos_x = pos_advance(s2_ent_r.pos_x, s2_px_r);
    tick_word.pos_y = pos_advance(s2_ent_r.pos_y, s2_py_r);
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    issue_nxt      = issue_r;
    s1_valid_nxt   = 1'b0;
    s1_addr_nxt    = s1_addr_r;
    rd_addr        = issue_r[ADDR_W-1:0];
    act_we         = 1'b0;
    act_waddr      = s2_addr_r;
    act_wdata      = 1'b0;
    dat_we         = 1'b0;
    dat_waddr      = s2_addr_r;
    dat_wdata      = tick_word;
    res_found_nxt  = res_found_r;
    res_index_nxt  = res_index_r;
    res_active_nxt = res_active_r;
    res_x_nxt      = res_x_r;
    res_y_nxt      = res_y_r;
    res_age_nxt    = res_age_r;
    unique case (state_r)
      ST_CLEAR: begin
        act_we    = 1'b1;
        act_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        rd_addr   = ADDR_W'(in_entry_index);
        issue_nxt = '0;
        if (in_acc) begin
          res_found_nxt  = 1'b0;
          res_index_nxt  = '0;
          res_active_nxt = 1'b0;
          res_x_nxt      = '0;
          res_y_nxt      = '0;
          res_age_nxt    = '0;
          unique case (cmd_t'(in_command))
            CMD_TICK:  state_nxt = ST_TICK;
            CMD_SPAWN: state_nxt = ST_SCAN;
            CMD_READ: begin
              res_index_nxt = in_entry_index;
              state_nxt     = ST_READ;
            end
            CMD_KILL: begin
              res_index_nxt = in_entry_index;
              act_we        = idx_in_range;
              act_waddr     = ADDR_W'(in_entry_index);
              state_nxt     = ST_DONE;
            end
          endcase
        end
      end
      ST_TICK: begin
        dat_we    = s2_valid_r;
        act_we    = s2_valid_r && s2_expire_r;
        if (issue_r < POOL_CNT) begin
          s1_valid_nxt = 1'b1;
          s1_addr_nxt  = issue_r[ADDR_W-1:0];
          issue_nxt    = issue_r + 1'b1;
        end else if (!s1_valid_r && !s2_valid_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_SCAN: begin
        if (s1_valid_r && !act_rd_r) begin
          act_we        = 1'b1;
          act_waddr     = s1_addr_r;
          act_wdata     = 1'b1;
          dat_we        = 1'b1;
          dat_waddr     = s1_addr_r;
          dat_wdata     = spawn_r;
          res_found_nxt = 1'b1;
          res_index_nxt = RIDX_W'(s1_addr_r);
          state_nxt     = ST_DONE;
        end else if (s1_valid_r && s1_addr_r == LAST_ADDR) begin
          state_nxt = ST_DONE;
        end else if (issue_r < POOL_CNT) begin
          s1_valid_nxt = 1'b1;
          s1_addr_nxt  = issue_r[ADDR_W-1:0];
          issue_nxt    = issue_r + 1'b1;
        end
      end
      ST_READ: begin
        if (in_range_r && act_rd_r) begin
          res_active_nxt = 1'b1;
          res_x_nxt      = dat_rd_r.pos_x;
          res_y_nxt      = dat_rd_r.pos_y;
          res_age_nxt    = dat_rd_r.age;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      issue_r     <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      issue_r    <= issue_nxt;
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= (state_r == ST_TICK) && s1_valid_r && act_rd_r;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r     <= s1_addr_nxt;
    s2_addr_r     <= s1_addr_r;
    s2_ent_r      <= {dat_rd_r[$bits(entry_t)-1:16], age_sat};
    s2_px_r       <= prod_x;
    s2_py_r       <= prod_y;
    s2_expire_r   <= (age_sat >= dat_rd_r.lifetime);
    res_found_r   <= res_found_nxt;
    res_index_r   <= res_index_nxt;
    res_active_r  <= res_active_nxt;
    res_x_r       <= res_x_nxt;
    res_y_r       <= res_y_nxt;
    res_age_r     <= res_age_nxt;
    if (in_acc) begin
      in_range_r <= idx_in_range;
      delta_r    <= in_delta_ms;
      spawn_r    <= '{pos_x: in_start_x, pos_y: in_start_y, dir_x: in_heading_x,
                      dir_y: in_heading_y, speed: in_speed, lifetime: in_lifetime_ms,
                      age: '0};
    end
    if (out_load) begin
      out_found_r  <= res_found_r;
      out_index_r  <= res_index_r;
      out_active_r <= res_active_r;
      out_x_r      <= res_x_r;
      out_y_r      <= res_y_r;
      out_age_r    <= res_age_r;
    end
  end

  // flag and entry memories, one write and one registered read each
  always_ff @(posedge clk) begin
    if (act_we) begin
      act_mem[act_waddr] <= act_wdata;
    end
    act_rd_r <= act_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (dat_we) begin
      dat_mem[dat_waddr] <= dat_wdata;
    end
    dat_rd_r <= dat_mem[rd_addr];
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_result_index = out_index_r;
  assign out_entry_active = out_active_r;
  assign out_read_x       = out_x_r;
  assign out_read_y       = out_y_r;
  assign out_read_age_ms  = out_age_r;

  `PPE_ASSERT_IMP(a_tick_no_overlap, s2_valid_r && s1_valid_nxt, s2_addr_r != s1_addr_nxt,
    "write-back collides with lookup of the same entry")
  `PPE_ASSERT_IMP(a_lookup_in_walk, s1_valid_r, state_r == ST_TICK || state_r == ST_SCAN,
    "lookup pipeline busy outside tick or spawn")
  `PPE_ASSERT_IMP(a_spawn_word_clean, out_valid_r && out_found_r,
    !out_active_r && out_age_r == 16'd0, "spawn word carries read fields")
  `PPE_ASSERT_NXT(a_done_loads, state_r == ST_DONE && !out_valid_r, out_valid_r,
    "finished command not presented")

endmodule

`default_nettype wire

FILE: verif/particle_pool_engine_unit_tb.sv
`timescale 1ns / 100ps

module particle_pool_engine_unit_tb;
  import ppe_pkg::*;

  localparam int CLK_HALF         = 5;
  localparam int RANDOM_WORDS     = 116;
  localparam int HOLD_AFTER_WORDS = 55;
  localparam int HOLD_OFF_CYCLES  = 6000;
  localparam int TAIL_CYCLES      = 50;
  localparam int CYCLE_LIMIT      = 3000000;
  localparam int DIRECTED_ROWS    = 24;

  typedef struct {
    cmd_t                cmd;
    logic [11:0]         index;
    logic signed [23:0]  sx;
    logic signed [23:0]  sy;
    logic signed [15:0]  hx;
    logic signed [15:0]  hy;
    logic [15:0]         spd;
    logic [15:0]         life;
    logic [9:0]          delta;
  } pool_cmd_t;

  typedef struct {
    logic                found;
    logic [11:0]         index;
    logic                active;
    logic signed [23:0]  x;
    logic signed [23:0]  y;
    logic [15:0]         age;
  } pool_result_t;

  typedef struct {
    pool_cmd_t           word;
    bit                  typed;
    pool_result_t        want;
  } pool_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_command = '0;
  logic [11:0]        in_entry_index = '0;
  logic signed [23:0] in_start_x = '0;
  logic signed [23:0] in_start_y = '0;
  logic signed [15:0] in_heading_x = '0;
  logic signed [15:0] in_heading_y = '0;
  logic [15:0]        in_speed = '0;
  logic [15:0]        in_lifetime_ms = '0;
  logic [9:0]         in_delta_ms = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_found;
  logic [11:0]        out_result_index;
  logic               out_entry_active;
  logic signed [23:0] out_read_x;
  logic signed [23:0] out_read_y;
  logic [15:0]        out_read_age_ms;

  bit                 slot_active [POOL_ENTRIES];
  logic signed [23:0] slot_x [POOL_ENTRIES];
  logic signed [23:0] slot_y [POOL_ENTRIES];
  logic signed [15:0] slot_dx [POOL_ENTRIES];
  logic signed [15:0] slot_dy [POOL_ENTRIES];
  logic [15:0]        slot_speed [POOL_ENTRIES];
  logic [15:0]        slot_life [POOL_ENTRIES];
  logic [15:0]        slot_age [POOL_ENTRIES];

  pool_result_t       pending_results [$];
  pool_result_t       head_result;
  int                 mismatch_count = 0;
  int                 cycle_count = 0;
  int                 words_sent = 0;
  int                 calm_left = 0;
  bit                 hold_done = 1'b0;

  pool_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{cmd: CMD_READ, index: 12'd0, default: '0}, 1'b1, '{default: '0}},
    '{'{cmd: CMD_READ, index: 12'd4095, default: '0}, 1'b1,
      '{index: 12'd4095, default: '0}},
    '{'{cmd: CMD_KILL, index: 12'd5, default: '0}, 1'b1, '{index: 12'd5, default: '0}},
    '{'{cmd: CMD_TICK, default: '0}, 1'b1, '{default: '0}},
    '{'{CMD_SPAWN, 12'd0, 24'sh7FFFFF, 24'sh800000, 16'sh4000, 16'shC000,
        16'hFFFF, 16'hFFFF, 10'd0}, 1'b1, '{found: 1'b1, index: 12'd0, default: '0}},
    '{'{CMD_SPAWN, 12'd0, 24'sh800000, 24'sh7FFFFF, 16'shC000, 16'sh4000,
        16'hFFFF, 16'hFFFF, 10'd0}, 1'b1, '{found: 1'b1, index: 12'd1, default: '0}},
    '{'{cmd: CMD_SPAWN, default: '0}, 1'b1, '{found: 1'b1, index: 12'd2, default: '0}},
    '{'{CMD_SPAWN, 12'd0, 24'sh003039, 24'shFFEF1F, 16'sh2D41, 16'shD2BF,
        16'h0180, 16'd5000, 10'd0}, 1'b1, '{found: 1'b1, index: 12'd3, default: '0}},
    '{'{CMD_SPAWN, 12'hFFF, 24'shFFFFFF, 24'sh000001, 16'shFFFF, 16'sh0001,
        16'h0001, 16'd1024, 10'h3FF}, 1'b1, '{found: 1'b1, index: 12'd4, default: '0}},
    '{'{cmd: CMD_READ, index: 12'd0, default: '0}, 1'b1,
      '{active: 1'b1, x: 24'sh7FFFFF, y: 24'sh800000, default: '0}},
    '{'{cmd: CMD_READ, index: 12'd2, default: '0}, 1'b1,
      '{index: 12'd2, active: 1'b1, default: '0}},
    '{'{cmd: CMD_TICK, delta: 10'h3FF, default: '0}, 1'b1, '{default: '0}},
    '{'{cmd: CMD_READ, index: 12'd0, default: '0}, 1'b0, '{default: '0}},
    '{'{cmd: CMD_READ, index: 12'd1, default: '0}, 1'b0, '{default: '0}},
    '{'{cmd: CMD_READ, index: 12'd2, default: '0}, 1'b1, '{index: 12'd2, default: '0}},
    '{'{cmd: CMD_READ, index: 12'd3, default: '0}, 1'b0, '{default: '0}},
    '{'{cmd: CMD_READ, index: 12'd4, default: '0}, 1'b0, '{default: '0}},
    '{'{cmd: CMD_KILL, index: 12'd1, default: '0}, 1'b1, '{index: 12'd1, default: '0}},
    '{'{cmd: CMD_READ, index: 12'd1, default: '0}, 1'b1, '{index: 12'd1, default: '0}},
    '{'{CMD_SPAWN, 12'd7, 24'sh123456, 24'shEDCBA9, 16'sh1234, 16'shE000,
        16'h0A5A, 16'hFFFF, 10'd17}, 1'b1, '{found: 1'b1, index: 12'd1, default: '0}},
    '{'{cmd: CMD_TICK, delta: 10'd512, default: '0}, 1'b1, '{default: '0}},
    '{'{cmd: CMD_READ, index: 12'd1, default: '0}, 1'b0, '{default: '0}},
    '{'{cmd: CMD_KILL, index: 12'd4095, default: '0}, 1'b1,
      '{index: 12'd4095, default: '0}},
    '{'{cmd: CMD_READ, index: 12'd3, default: '0}, 1'b0, '{default: '0}}
  };

  particle_pool_engine_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_entry_index   (in_entry_index),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_heading_x     (in_heading_x),
    .in_heading_y     (in_heading_y),
    .in_speed         (in_speed),
    .in_lifetime_ms   (in_lifetime_ms),
    .in_delta_ms      (in_delta_ms),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_found        (out_found),
    .out_result_index (out_result_index),
    .out_entry_active (out_entry_active),
    .out_read_x       (out_read_x),
    .out_read_y       (out_read_y),
    .out_read_age_ms  (out_read_age_ms)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic logic signed [23:0] step_position(
    input logic signed [23:0] pos,
    input logic signed [15:0] dir,
    input logic [15:0]        spd
  );
    longint prod;
    longint sum;
    prod = longint'(dir) * longint'(spd);
    sum  = longint'(pos) + (prod >>> 14);
    if (sum > 64'sd8388607) begin
      sum = 64'sd8388607;
    end
    if (sum < -64'sd8388608) begin
      sum = -64'sd8388608;
    end
    return 24'(sum);
  endfunction

  // applies one command to the pool copy and returns the word it answers with
  function automatic pool_result_t pool_apply(input pool_cmd_t w);
    pool_result_t res;
    int           i;
    int           slot;
    int           aged;
    res  = '{default: '0};
    slot = -1;
    case (w.cmd)
      CMD_TICK: begin
        for (i = 0; i < POOL_ENTRIES; i++) begin
          if (slot_active[i]) begin
            slot_x[i] = step_position(slot_x[i], slot_dx[i], slot_speed[i]);
            slot_y[i] = step_position(slot_y[i], slot_dy[i], slot_speed[i]);
            aged = int'(slot_age[i]) + int'(w.delta);
            if (aged > 65535) begin
              aged = 65535;
            end
            slot_age[i] = 16'(aged);
            if (aged >= int'(slot_life[i])) begin
              slot_active[i] = 1'b0;
            end
          end
        end
      end
      CMD_SPAWN: begin
        for (i = 0; i < POOL_ENTRIES; i++) begin
          if (!slot_active[i]) begin
            slot = i;
            break;
          end
        end
        if (slot >= 0) begin
          slot_x[slot]      = w.sx;
          slot_y[slot]      = w.sy;
          slot_dx[slot]     = w.hx;
          slot_dy[slot]     = w.hy;
          slot_speed[slot]  = w.spd;
          slot_life[slot]   = w.life;
          slot_age[slot]    = '0;
          slot_active[slot] = 1'b1;
          res.found = 1'b1;
          res.index = 12'(slot);
        end
      end
      CMD_READ: begin
        res.index = w.index;
        if (int'(w.index) < POOL_ENTRIES && slot_active[w.index]) begin
          res.active = 1'b1;
          res.x      = slot_x[w.index];
          res.y      = slot_y[w.index];
          res.age    = slot_age[w.index];
        end
      end
      default: begin
        res.index = w.index;
        if (int'(w.index) < POOL_ENTRIES) begin
          slot_active[w.index] = 1'b0;
        end
      end
    endcase
    return res;
  endfunction

  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return $urandom_range(1, 2);
    end else if (r < 92) begin
      return $urandom_range(3, 8);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  task automatic send_word(input pool_cmd_t w, input bit typed, input pool_result_t want);
    pool_result_t predicted;
    int           gap;
    in_valid       <= 1'b1;
    in_command     <= w.cmd;
    in_entry_index <= w.index;
    in_start_x     <= w.sx;
    in_start_y     <= w.sy;
    in_heading_x   <= w.hx;
    in_heading_y   <= w.hy;
    in_speed       <= w.spd;
    in_lifetime_ms <= w.life;
    in_delta_ms    <= w.delta;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predicted = pool_apply(w);
    pending_results.push_back(typed ? want : predicted);
    words_sent++;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else if ($urandom_range(0, 19) == 0) begin
      calm_left = $urandom_range(8, 20);
      gap = 0;
    end else begin
      gap = ($urandom_range(0, 1) == 0) ? 0 : idle_span();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // random stalls, with one long hold-off once the pool has some traffic
  always begin : out_stall_drive
    int span;
    @(posedge clk);
    if (!hold_done && words_sent >= HOLD_AFTER_WORDS) begin
      hold_done = 1'b1;
      out_stall <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clk);
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 99) < 60) begin
      out_stall <= 1'b0;
      span = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 4);
      repeat (span - 1) @(posedge clk);
    end else begin
      out_stall <= 1'b1;
      span = idle_span();
      repeat (span - 1) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch("word with nothing pending", 64'(out_result_index), 64'd0);
      end else begin
        head_result = pending_results.pop_front();
        if (out_found !== head_result.found)
          report_mismatch("found", 64'(out_found), 64'(head_result.found));
        if (out_result_index !== head_result.index)
          report_mismatch("result_index", 64'(out_result_index), 64'(head_result.index));
        if (out_entry_active !== head_result.active)
          report_mismatch("entry_active", 64'(out_entry_active), 64'(head_result.active));
        if (out_read_x !== head_result.x)
          report_mismatch("read_x", 64'(out_read_x), 64'(head_result.x));
        if (out_read_y !== head_result.y)
          report_mismatch("read_y", 64'(out_read_y), 64'(head_result.y));
        if (out_read_age_ms !== head_result.age)
          report_mismatch("read_age_ms", 64'(out_read_age_ms), 64'(head_result.age));
      end
    end
  end

  initial begin
    pool_cmd_t w;
    int        n;
    int        r;
    foreach (slot_active[i]) slot_active[i] = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
    end

    for (n = 0; n < RANDOM_WORDS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        w.cmd = CMD_SPAWN;
      end else if (r < 65) begin
        w.cmd = CMD_READ;
      end else if (r < 75) begin
        w.cmd = CMD_KILL;
      end else begin
        w.cmd = CMD_TICK;
      end
      w.index = ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(0, 47));
      w.sx    = 24'($urandom);
      w.sy    = 24'($urandom);
      if ($urandom_range(0, 7) == 0) begin
        w.sx = w.sx[23] ? 24'sh800000 : 24'sh7FFFFF;
        w.sy = w.sy[23] ? 24'sh800000 : 24'sh7FFFFF;
      end
      w.hx    = 16'(int'($urandom_range(0, 32768)) - 16384);
      w.hy    = 16'(int'($urandom_range(0, 32768)) - 16384);
      w.spd   = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1023));
      r = $urandom_range(0, 99);
      if (r < 20) begin
        w.life = 16'hFFFF;
      end else if (r < 50) begin
        w.life = 16'($urandom);
      end else begin
        w.life = 16'($urandom_range(0, 4000));
      end
      w.delta = 10'($urandom);
      send_word(w, 1'b0, '{default: '0});
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/ppe_pkg.sv
hdl/particle_pool_engine_unit.sv
verif/particle_pool_engine_unit_tb.sv
